/* rtl/ics_pkg.sv */
// ============================================================================
// ics_pkg
// Shared types and constants for the streaming Internet checksum block.
// ============================================================================
package ics_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_req;

    localparam logic [1:0] C_MODE_IP  = 2'd0;
    localparam logic [1:0] C_MODE_UDP = 2'd1;
    localparam logic [1:0] C_MODE_TCP = 2'd2;

    localparam logic [15:0] C_PROTO_UDP         = 16'd17;
    localparam logic [15:0] C_PROTO_TCP         = 16'd6;
    localparam logic [15:0] C_PSEUDO_ADDR_BYTES = 16'd8;

endpackage

/* rtl/ics_req_if.sv */
// ============================================================================
// ics_req_if
// Byte request channel: valid/ready handshake with one byte and a last mark.
// ============================================================================
interface ics_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/ics_rsp_if.sv */
// ============================================================================
// ics_rsp_if
// Checksum result channel: valid/ready handshake with a 16-bit checksum.
// ============================================================================
interface ics_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] checksum_value;

    modport source (output valid, output checksum_value, input ready);
    modport sink   (input valid, input checksum_value, output ready);
endinterface

/* rtl/ics_core.sv */
// ============================================================================
// ics_core
// Running one's complement sum over byte pairs, byte count, and the final
// folded and complemented checksum with optional pseudo-header terms.
// ============================================================================
module ics_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  ics_pkg::t_req i_req,
    input  logic [1:0]    i_mode,
    output logic [15:0]   o_checksum
);

    logic [15:0] r_running_sum;
    logic [15:0] r_byte_count;
    logic [7:0]  r_held_high;
    logic        r_odd;

    logic [15:0] n_running_sum;
    logic [15:0] n_byte_count;
    logic [7:0]  n_held_high;
    logic        n_odd;

    logic [15:0] count_inc;
    logic [15:0] word;
    logic [16:0] pair_sum;
    logic [15:0] pair_fold;
    logic [15:0] proto_term;
    logic [15:0] len_term;
    logic        pseudo_en;
    logic [17:0] final_sum;
    logic [16:0] fold1;
    logic [15:0] fold2;

    assign count_inc = r_byte_count + 16'd1;
    assign word      = r_odd ? {r_held_high, i_req.data_byte} : {i_req.data_byte, 8'h00};
    assign pair_sum  = {1'b0, r_running_sum} + {1'b0, word};
    assign pair_fold = pair_sum[15:0] + {15'd0, pair_sum[16]};

    always_comb begin
        case (i_mode)
            ics_pkg::C_MODE_IP: begin
                proto_term = 16'd0;
                pseudo_en  = 1'b0;
            end
            ics_pkg::C_MODE_UDP: begin
                proto_term = ics_pkg::C_PROTO_UDP;
                pseudo_en  = 1'b1;
            end
            ics_pkg::C_MODE_TCP: begin
                proto_term = ics_pkg::C_PROTO_TCP;
                pseudo_en  = 1'b1;
            end
            default: begin
                proto_term = 16'd0;
                pseudo_en  = 1'b0;
            end
        endcase
    end

    assign len_term  = pseudo_en ? (count_inc - ics_pkg::C_PSEUDO_ADDR_BYTES) : 16'd0;
    assign final_sum = {2'b00, r_running_sum} + {2'b00, word}
                     + {2'b00, proto_term} + {2'b00, len_term};
    assign fold1      = {1'b0, final_sum[15:0]} + {15'd0, final_sum[17:16]};
    assign fold2      = fold1[15:0] + {15'd0, fold1[16]};
    assign o_checksum = ~fold2;

    always_comb begin
        n_running_sum = r_running_sum;
        n_byte_count  = r_byte_count;
        n_held_high   = r_held_high;
        n_odd         = r_odd;
        if (i_step) begin
            if (i_req.last_byte) begin
                n_running_sum = 16'd0;
                n_byte_count  = 16'd0;
                n_held_high   = 8'd0;
                n_odd         = 1'b0;
            end else begin
                n_byte_count = count_inc;
                if (r_odd) begin
                    n_running_sum = pair_fold;
                    n_odd         = 1'b0;
                end else begin
                    n_held_high = i_req.data_byte;
                    n_odd       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_sum <= 16'd0;
            r_byte_count  <= 16'd0;
            r_held_high   <= 8'd0;
            r_odd         <= 1'b0;
        end else begin
            r_running_sum <= n_running_sum;
            r_byte_count  <= n_byte_count;
            r_held_high   <= n_held_high;
            r_odd         <= n_odd;
        end
    end

endmodule

/* rtl/internet_checksum_stream_top.sv */
// ============================================================================
// internet_checksum_stream_top
// Streaming Internet checksum over a byte region with a last-byte mark.
// ============================================================================
// Takes one byte per cycle with no gaps of its own. A byte sits in the input
// register and is folded into the running 16-bit one's complement sum at the
// next clock edge. On the last byte the complemented checksum lands in the
// result register at that same edge. A last byte holds in the input register
// only while the previous checksum is still waiting to be read. Checksum mode 1
// (UDP) or 2 (TCP) adds the protocol number and the byte count minus 8, for a
// region that starts at the IP source address; modes 0 and 3 add nothing.
// Write the mode only while no region is in flight.
// ============================================================================
module internet_checksum_stream_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    ics_req_if.sink    i_req,
    ics_rsp_if.source  o_rsp
);

    logic          r_mode;
    logic [1:0]    r_mode_val;
    logic          r_in_valid;
    ics_pkg::t_req r_in;
    logic          r_out_valid;
    logic [15:0]   r_out_sum;

    logic          out_free;
    logic          core_step;
    logic          in_take;
    logic [15:0]   core_checksum;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign core_step   = r_in_valid && (!r_in.last_byte || out_free);
    assign in_take     = i_req.valid && i_req.ready;
    assign i_req.ready = !r_in_valid || core_step;

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.checksum_value = r_out_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_mode_val <= ics_pkg::C_MODE_IP;
        end else if (i_cfg_we) begin
            r_mode     <= 1'b1;
            r_mode_val <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.data_byte <= i_req.data_byte;
            r_in.last_byte <= i_req.last_byte;
        end
    end

    ics_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (core_step),
        .i_req      (r_in),
        .i_mode     (r_mode_val),
        .o_checksum (core_checksum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_step && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_step && r_in.last_byte) begin
            r_out_sum <= core_checksum;
        end
    end

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid && r_in.last_byte))
        else $error("result appeared without a last byte");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !core_step) |=> (r_in_valid && $stable(r_in)))
        else $error("pending request lost or overwritten");

    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (core_step && r_in.last_byte) |-> (!r_out_valid || o_rsp.ready))
        else $error("result register overwritten while full");

    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_mode |-> (r_mode_val == ics_pkg::C_MODE_IP))
        else $error("mode changed without a configuration write");

endmodule

/* test/internet_checksum_stream_top_tb.sv */
// ============================================================================
// internet_checksum_stream_top_tb
// Drives byte regions in every checksum mode through the request channel with
// random gaps on both sides, predicts each checksum from its own copy of the
// one's complement sum, and compares every result with the oldest prediction.
// ============================================================================
module internet_checksum_stream_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         RANDOM_ITEMS  = 650;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_data;

    ics_req_if req_if();
    ics_rsp_if rsp_if();

    internet_checksum_stream_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    logic [1:0]  model_mode;
    logic [15:0] model_sum;
    logic [15:0] model_count;
    logic [7:0]  model_high;
    logic        model_odd;
    logic [15:0] csum_expected[$];

    int  fail_count;
    int  bytes_sent;
    bit  no_idle;
    bit  rst_done;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic int pick_gap();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            return 8'h00;
        end else if (r == 1) begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic csum_clear();
        model_sum   = 16'd0;
        model_count = 16'd0;
        model_high  = 8'd0;
        model_odd   = 1'b0;
    endtask

    task automatic csum_take_byte(input logic [7:0] data, input logic is_last);
        logic [15:0] total;
        model_count = model_count + 16'd1;
        if (!is_last) begin
            if (model_odd) begin
                model_sum = ones_add(model_sum, {model_high, data});
                model_odd = 1'b0;
            end else begin
                model_high = data;
                model_odd  = 1'b1;
            end
        end else begin
            if (model_odd) begin
                total = ones_add(model_sum, {model_high, data});
            end else begin
                total = ones_add(model_sum, {data, 8'h00});
            end
            if (model_mode == ics_pkg::C_MODE_UDP || model_mode == ics_pkg::C_MODE_TCP) begin
                total = ones_add(total, (model_mode == ics_pkg::C_MODE_UDP)
                                        ? ics_pkg::C_PROTO_UDP : ics_pkg::C_PROTO_TCP);
                total = ones_add(total, model_count - ics_pkg::C_PSEUDO_ADDR_BYTES);
            end
            csum_expected.push_back(~total);
            csum_clear();
        end
    endtask

    task automatic send_byte(input logic [7:0] data, input logic is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid     = 1'b1;
        req_if.data_byte = data;
        req_if.last_byte = is_last;
        do @(posedge i_clk); while (!req_if.ready);
        csum_take_byte(data, is_last);
        bytes_sent++;
    endtask

    task automatic send_region(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(pick_byte(), i == len - 1);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (csum_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_checksum_mode(input logic [1:0] mode);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = mode;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        model_mode = mode;
    endtask

    task automatic test_directed();
        logic [7:0] udp_region[8];
        udp_region = '{8'hC0, 8'hA8, 8'h00, 8'h01, 8'hC0, 8'hA8, 8'h00, 8'hC7};
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1);
        set_checksum_mode(ics_pkg::C_MODE_UDP);
        foreach (udp_region[i]) begin
            send_byte(udp_region[i], i == 7);
        end
        set_checksum_mode(ics_pkg::C_MODE_TCP);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
        set_checksum_mode(MODE_RESERVED);
        send_byte(8'hAB, 1'b0);
        send_byte(8'hCD, 1'b1);
        set_checksum_mode(ics_pkg::C_MODE_IP);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b1);
    endtask

    task automatic test_random_regions();
        logic [1:0] mode_plan[6];
        int         stop_at;
        int         len;
        mode_plan = '{ics_pkg::C_MODE_UDP, ics_pkg::C_MODE_IP, ics_pkg::C_MODE_TCP,
                      MODE_RESERVED, ics_pkg::C_MODE_UDP, ics_pkg::C_MODE_TCP};
        stop_at = bytes_sent + RANDOM_ITEMS;
        for (int p = 0; bytes_sent < stop_at; p++) begin
            set_checksum_mode(mode_plan[p % 6]);
            repeat (6) begin
                no_idle = ($urandom_range(0, 5) == 0);
                if (model_mode == ics_pkg::C_MODE_UDP || model_mode == ics_pkg::C_MODE_TCP) begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 7)
                                                      : $urandom_range(8, 40);
                end else begin
                    len = $urandom_range(1, 24);
                end
                send_region(len);
                if ($urandom_range(0, 3) == 0) begin
                    wait_idle();
                end
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_data       = ics_pkg::C_MODE_IP;
        req_if.valid     = 1'b0;
        req_if.data_byte = 8'h00;
        req_if.last_byte = 1'b0;
        rsp_if.ready     = 1'b0;
        fail_count       = 0;
        bytes_sent       = 0;
        no_idle          = 1'b0;
        rst_done         = 1'b0;
        model_mode       = ics_pkg::C_MODE_IP;
        csum_clear();
        repeat (10) @(negedge i_clk);
        i_rst_n  = 1'b1;
        rst_done = 1'b1;

        test_directed();
        test_random_regions();
        wait_idle();

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        int          stall;
        logic [15:0] want;
        wait (rst_done);
        forever begin
            stall = pick_gap();
            repeat (stall) begin
                @(negedge i_clk);
                rsp_if.ready = 1'b0;
            end
            @(negedge i_clk);
            rsp_if.ready = 1'b1;
            do @(posedge i_clk); while (rsp_if.valid !== 1'b1);
            if (csum_expected.size() == 0) begin
                $error("checksum_value: expected none, actual %h", rsp_if.checksum_value);
                fail_count++;
            end else begin
                want = csum_expected.pop_front();
                if (rsp_if.checksum_value !== want) begin
                    $error("checksum_value: expected %h, actual %h",
                           want, rsp_if.checksum_value);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
